/* rtl/i2c_master_byte_transactions_unit_assert.svh */
// Assertion macros for the I2C byte transaction unit.
// Included by the top level; no other dependencies.
`ifndef I2C_MASTER_BYTE_TRANSACTIONS_UNIT_ASSERT_SVH
`define I2C_MASTER_BYTE_TRANSACTIONS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cm implication check failed");

// The expression must never be true.
`define I2CM_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("i2cm forbidden condition seen");

`endif

/* rtl/i2cm_pkg.sv */
// Shared types, constants and the bus phase program of the I2C byte transaction unit.
// No dependencies.
`default_nettype none

package i2cm_pkg;

   // Command codes of an input word.
   localparam logic [1:0] CmdTick  = 2'd0;
   localparam logic [1:0] CmdWrite = 2'd1;
   localparam logic [1:0] CmdRead  = 2'd2;

   localparam logic [15:0] UnitTicksReset = 16'd100;
   localparam int          QueueDepthDefault = 2;

   // Program step numbers with a meaning of their own.
   localparam logic [5:0] StepIdle       = 6'd0;
   localparam logic [5:0] StepWriteFirst = 6'd1;
   localparam logic [5:0] StepReadFirst  = 6'd25;

   typedef enum logic [1:0] {
      SdaLo,
      SdaHi,
      SdaBit
   } sda_sel_type;

   typedef enum logic [3:0] {
      ActNone,
      ActLoadDev,
      ActLoadAddr,
      ActLoadData,
      ActLoadDevRd,
      ActTxBit,
      ActAck,
      ActRxClr,
      ActRxBit,
      ActRxLoop,
      ActEnd
   } act_type;

   typedef struct packed {
      logic        scl;
      sda_sel_type sda_sel;
      logic [1:0]  units;
      act_type     act;
   } phase_type;

   // One classified input word as it waits in the queue.
   typedef struct packed {
      logic       start_write;
      logic       start_read;
      logic [7:0] dev_byte;
      logic [7:0] reg_address;
      logic [7:0] write_data;
      logic       sda_in;
   } item_type;

   // Queue status seen by the engine and the top level.
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   function automatic phase_type mk_phase(input logic scl, input sda_sel_type sel,
                                          input logic [1:0] units, input act_type act);
      phase_type p;
      p.scl     = scl;
      p.sda_sel = sel;
      p.units   = units;
      p.act     = act;
      return p;
   endfunction

   // Phase program: line levels, length in delay units and the action at phase end.
   function automatic phase_type prog_phase(input logic [5:0] step);
      phase_type p;
      case (step)
         6'd0:  p = mk_phase(1'b1, SdaHi,  2'd1, ActNone);
         // Write: START.
         6'd1:  p = mk_phase(1'b1, SdaHi,  2'd2, ActNone);
         6'd2:  p = mk_phase(1'b1, SdaLo,  2'd1, ActNone);
         6'd3:  p = mk_phase(1'b0, SdaLo,  2'd1, ActLoadDev);
         // Device byte.
         6'd4:  p = mk_phase(1'b0, SdaBit, 2'd1, ActNone);
         6'd5:  p = mk_phase(1'b1, SdaBit, 2'd1, ActNone);
         6'd6:  p = mk_phase(1'b0, SdaBit, 2'd1, ActTxBit);
         6'd7:  p = mk_phase(1'b0, SdaHi,  2'd1, ActNone);
         6'd8:  p = mk_phase(1'b1, SdaHi,  2'd3, ActAck);
         6'd9:  p = mk_phase(1'b0, SdaHi,  2'd3, ActLoadAddr);
         // Address byte.
         6'd10: p = mk_phase(1'b0, SdaBit, 2'd1, ActNone);
         6'd11: p = mk_phase(1'b1, SdaBit, 2'd1, ActNone);
         6'd12: p = mk_phase(1'b0, SdaBit, 2'd1, ActTxBit);
         6'd13: p = mk_phase(1'b0, SdaHi,  2'd1, ActNone);
         6'd14: p = mk_phase(1'b1, SdaHi,  2'd3, ActAck);
         6'd15: p = mk_phase(1'b0, SdaHi,  2'd3, ActLoadData);
         // Data byte.
         6'd16: p = mk_phase(1'b0, SdaBit, 2'd1, ActNone);
         6'd17: p = mk_phase(1'b1, SdaBit, 2'd1, ActNone);
         6'd18: p = mk_phase(1'b0, SdaBit, 2'd1, ActTxBit);
         6'd19: p = mk_phase(1'b0, SdaHi,  2'd1, ActNone);
         6'd20: p = mk_phase(1'b1, SdaHi,  2'd3, ActAck);
         6'd21: p = mk_phase(1'b0, SdaHi,  2'd3, ActNone);
         // STOP.
         6'd22: p = mk_phase(1'b0, SdaLo,  2'd1, ActNone);
         6'd23: p = mk_phase(1'b1, SdaLo,  2'd1, ActNone);
         6'd24: p = mk_phase(1'b1, SdaHi,  2'd1, ActEnd);
         // Read: START.
         6'd25: p = mk_phase(1'b1, SdaHi,  2'd2, ActNone);
         6'd26: p = mk_phase(1'b1, SdaLo,  2'd1, ActNone);
         6'd27: p = mk_phase(1'b0, SdaLo,  2'd1, ActLoadDev);
         // Device byte.
         6'd28: p = mk_phase(1'b0, SdaBit, 2'd1, ActNone);
         6'd29: p = mk_phase(1'b1, SdaBit, 2'd1, ActNone);
         6'd30: p = mk_phase(1'b0, SdaBit, 2'd1, ActTxBit);
         6'd31: p = mk_phase(1'b0, SdaHi,  2'd1, ActNone);
         6'd32: p = mk_phase(1'b1, SdaHi,  2'd3, ActAck);
         6'd33: p = mk_phase(1'b0, SdaHi,  2'd3, ActLoadAddr);
         // Address byte.
         6'd34: p = mk_phase(1'b0, SdaBit, 2'd1, ActNone);
         6'd35: p = mk_phase(1'b1, SdaBit, 2'd1, ActNone);
         6'd36: p = mk_phase(1'b0, SdaBit, 2'd1, ActTxBit);
         6'd37: p = mk_phase(1'b0, SdaHi,  2'd1, ActNone);
         6'd38: p = mk_phase(1'b1, SdaHi,  2'd3, ActAck);
         6'd39: p = mk_phase(1'b0, SdaHi,  2'd3, ActNone);
         // Pause, STOP, pause.
         6'd40: p = mk_phase(1'b0, SdaHi,  2'd1, ActNone);
         6'd41: p = mk_phase(1'b0, SdaLo,  2'd1, ActNone);
         6'd42: p = mk_phase(1'b1, SdaLo,  2'd1, ActNone);
         6'd43: p = mk_phase(1'b1, SdaHi,  2'd1, ActNone);
         6'd44: p = mk_phase(1'b1, SdaHi,  2'd1, ActNone);
         // Repeated START.
         6'd45: p = mk_phase(1'b1, SdaHi,  2'd2, ActNone);
         6'd46: p = mk_phase(1'b1, SdaLo,  2'd1, ActNone);
         6'd47: p = mk_phase(1'b0, SdaLo,  2'd1, ActLoadDevRd);
         // Device byte with the read bit.
         6'd48: p = mk_phase(1'b0, SdaBit, 2'd1, ActNone);
         6'd49: p = mk_phase(1'b1, SdaBit, 2'd1, ActNone);
         6'd50: p = mk_phase(1'b0, SdaBit, 2'd1, ActTxBit);
         6'd51: p = mk_phase(1'b0, SdaHi,  2'd1, ActNone);
         6'd52: p = mk_phase(1'b1, SdaHi,  2'd3, ActAck);
         6'd53: p = mk_phase(1'b0, SdaHi,  2'd3, ActRxClr);
         // Receive eight bits.
         6'd54: p = mk_phase(1'b0, SdaHi,  2'd1, ActNone);
         6'd55: p = mk_phase(1'b1, SdaHi,  2'd2, ActRxBit);
         6'd56: p = mk_phase(1'b0, SdaHi,  2'd2, ActRxLoop);
         // NACK clock and pause.
         6'd57: p = mk_phase(1'b1, SdaHi,  2'd1, ActNone);
         6'd58: p = mk_phase(1'b0, SdaHi,  2'd1, ActNone);
         6'd59: p = mk_phase(1'b0, SdaHi,  2'd1, ActNone);
         // STOP and pause.
         6'd60: p = mk_phase(1'b0, SdaLo,  2'd1, ActNone);
         6'd61: p = mk_phase(1'b1, SdaLo,  2'd1, ActNone);
         6'd62: p = mk_phase(1'b1, SdaHi,  2'd1, ActNone);
         6'd63: p = mk_phase(1'b1, SdaHi,  2'd1, ActEnd);
         default: p = mk_phase(1'b1, SdaHi, 2'd1, ActNone);
      endcase
      return p;
   endfunction

   // Phase length in ticks: units (one to three) times the delay unit, zero read as one.
   function automatic logic [17:0] phase_len(input logic [1:0] units,
                                             input logic [15:0] unit_ticks);
      logic [15:0] u;
      logic [17:0] len;
      u = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
      case (units)
         2'd1:    len = {2'b00, u};
         2'd2:    len = {1'b0, u, 1'b0};
         2'd3:    len = {2'b00, u} + {1'b0, u, 1'b0};
         default: len = 18'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

/* rtl/i2cm_front.sv */
// Front end of the I2C byte transaction unit: takes input words, decodes the
// command and holds them in a short queue. Depends on i2cm_pkg.
`default_nettype none

module i2cm_front #(
   parameter int QueueDepth = i2cm_pkg::QueueDepthDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_command,
   input  wire logic [7:0]                req_dev_byte,
   input  wire logic [7:0]                req_reg_address,
   input  wire logic [7:0]                req_write_data,
   input  wire logic                      req_sda_in,
   output i2cm_pkg::item_type             item,
   output i2cm_pkg::queue_status_type     status,
   input  wire logic                      item_pop
);

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(QueueDepth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(QueueDepth);

   i2cm_pkg::item_type entry_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   i2cm_pkg::item_type  decoded;
   logic                push;

   // Decode the command; the reserved code counts as a plain tick.
   always_comb begin
      decoded.start_write = (req_command == i2cm_pkg::CmdWrite);
      decoded.start_read  = (req_command == i2cm_pkg::CmdRead);
      decoded.dev_byte    = req_dev_byte;
      decoded.reg_address = req_reg_address;
      decoded.write_data  = req_write_data;
      decoded.sda_in      = req_sda_in;
   end

   assign req_ready    = (count_ff != CntFull);
   assign push         = req_valid && req_ready;
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == CntFull);
   assign item         = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

/* rtl/i2cm_engine.sv */
// Back end of the I2C byte transaction unit: steps the bus phase program one word per cycle
// while the result register is free or being emptied, and registers the result. Depends on i2cm_pkg.
`default_nettype none

module i2cm_engine (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [15:0]               unit_ticks,
   input  wire i2cm_pkg::item_type        item,
   input  wire i2cm_pkg::queue_status_type status,
   output logic                           item_pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_scl_out,
   output logic                           rsp_sda_out,
   output logic                           rsp_busy_res,
   output logic                           rsp_done_res,
   output logic [7:0]                     rsp_read_data,
   output logic                           rsp_ack_ok
);

   logic [5:0]  step_ff, step_in;
   logic [17:0] delay_ff, delay_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  rx_byte_ff, rx_byte_in;
   logic [24:0] latched_ff, latched_in;
   logic        ack_ff, ack_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in_q;
   logic        done_ff, done_in;

   logic [5:0]  cur_step;
   logic [17:0] cur_delay;
   logic [5:0]  next_step;
   logic [3:0]  bit_inc;
   i2cm_pkg::phase_type ph;
   i2cm_pkg::phase_type next_ph;

   // A word moves on when the result register is free or being emptied.
   assign item_pop = status.valid && (!rsp_valid_ff || rsp_ready);

   // One tick of the phase program.
   always_comb begin
      step_in    = step_ff;
      delay_in   = delay_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      rx_byte_in = rx_byte_ff;
      latched_in = latched_ff;
      ack_in     = ack_ff;
      scl_in     = 1'b1;
      sda_in_q   = 1'b1;
      done_in    = 1'b0;
      cur_step   = step_ff;
      cur_delay  = delay_ff;
      next_step  = step_ff;
      bit_inc    = bit_cnt_ff + 4'd1;
      ph         = i2cm_pkg::prog_phase(step_ff);
      next_ph    = ph;

      // A command starts a transaction only when idle.
      if (step_ff == i2cm_pkg::StepIdle && (item.start_write || item.start_read)) begin
         latched_in = {item.start_read, item.dev_byte, item.reg_address, item.write_data};
         ack_in     = 1'b1;
         cur_step   = item.start_write ? i2cm_pkg::StepWriteFirst
                                       : i2cm_pkg::StepReadFirst;
         ph         = i2cm_pkg::prog_phase(cur_step);
         cur_delay  = i2cm_pkg::phase_len(ph.units, unit_ticks);
      end
      step_in  = cur_step;
      delay_in = cur_delay;

      if (cur_step != i2cm_pkg::StepIdle) begin
         scl_in = ph.scl;
         case (ph.sda_sel)
            i2cm_pkg::SdaLo:  sda_in_q = 1'b0;
            i2cm_pkg::SdaBit: sda_in_q = shift_ff[7];
            default:          sda_in_q = 1'b1;
         endcase

         if (cur_delay > 18'd1) begin
            delay_in = cur_delay - 18'd1;
         end else begin
            // End of phase: run its action and pick the next step.
            next_step = cur_step + 6'd1;
            case (ph.act)
               i2cm_pkg::ActLoadDev: begin
                  shift_in   = latched_ff[23:16];
                  bit_cnt_in = 4'd0;
               end
               i2cm_pkg::ActLoadAddr: begin
                  shift_in   = latched_ff[15:8];
                  bit_cnt_in = 4'd0;
               end
               i2cm_pkg::ActLoadData: begin
                  shift_in   = latched_ff[7:0];
                  bit_cnt_in = 4'd0;
               end
               i2cm_pkg::ActLoadDevRd: begin
                  shift_in   = {latched_ff[23:17], 1'b1};
                  bit_cnt_in = 4'd0;
               end
               i2cm_pkg::ActTxBit: begin
                  shift_in   = {shift_ff[6:0], 1'b0};
                  bit_cnt_in = bit_inc;
                  if (bit_inc < 4'd8) begin
                     next_step = cur_step - 6'd2;
                  end
               end
               i2cm_pkg::ActAck: begin
                  if (item.sda_in) begin
                     ack_in = 1'b0;
                  end
               end
               i2cm_pkg::ActRxClr: begin
                  shift_in   = 8'd0;
                  bit_cnt_in = 4'd0;
               end
               i2cm_pkg::ActRxBit: begin
                  shift_in = {shift_ff[6:0], item.sda_in};
               end
               i2cm_pkg::ActRxLoop: begin
                  bit_cnt_in = bit_inc;
                  if (bit_inc < 4'd8) begin
                     next_step = cur_step - 6'd1;
                  end else begin
                     rx_byte_in = shift_ff;
                  end
               end
               i2cm_pkg::ActEnd: begin
                  next_step = i2cm_pkg::StepIdle;
                  done_in   = 1'b1;
               end
               default: begin
               end
            endcase
            next_ph  = i2cm_pkg::prog_phase(next_step);
            step_in  = next_step;
            delay_in = (next_step != i2cm_pkg::StepIdle)
                       ? i2cm_pkg::phase_len(next_ph.units, unit_ticks) : 18'd0;
         end
      end
   end

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= i2cm_pkg::StepIdle;
         delay_ff     <= '0;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         rx_byte_ff   <= '0;
         latched_ff   <= '0;
         ack_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            step_ff    <= step_in;
            delay_ff   <= delay_in;
            bit_cnt_ff <= bit_cnt_in;
            shift_ff   <= shift_in;
            rx_byte_ff <= rx_byte_in;
            latched_ff <= latched_in;
            ack_ff     <= ack_in;
         end
      end
   end

   // Result payload, loaded with each word.
   always_ff @(posedge clock) begin
      if (item_pop) begin
         scl_ff  <= scl_in;
         sda_ff  <= sda_in_q;
         done_ff <= done_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_out   = scl_ff;
   assign rsp_sda_out   = sda_ff;
   assign rsp_busy_res  = (step_ff != i2cm_pkg::StepIdle);
   assign rsp_done_res  = done_ff;
   assign rsp_read_data = rx_byte_ff;
   assign rsp_ack_ok    = ack_ff;

endmodule

`default_nettype wire

/* rtl/i2c_master_byte_transactions_unit.sv */
// I2C byte transaction unit, top level: configuration register, front queue and
// phase engine. Depends on i2cm_pkg, i2cm_front, i2cm_engine and the assertion header.
//
// Usage: every word on the req_ channel is one time tick of the bus. req_command
// starts a write (1) or read (2) transaction when the unit is idle and is ignored
// otherwise; req_sda_in is the sampled SDA level of that tick. Every word yields
// exactly one result word on the rsp_ channel with the SCL and SDA drive levels,
// busy and done flags, the last read byte and the acknowledge summary.
// The csr_ port writes unit_ticks, the length of one bus delay unit in ticks; the user
// must see that it is written only while no word is in flight, which the block does not enforce.
// A word is written into the front queue when accepted; the engine takes it from
// the queue once the result register is free or being emptied and loads its result
// into the result register, from which the receiver takes it.
// Throughput: one word per cycle while the result register is free or being emptied;
// the phase engine steps the program counter and delay counter once per word.
// Reset empties the queue, clears the result valid flag, puts the engine in its
// idle step and sets unit_ticks to 100. When the receiver stalls the result holds,
// the engine stops, and the queue keeps taking words until it is full, after which
// req_ready drops.
`default_nettype none
`include "i2c_master_byte_transactions_unit_assert.svh"

module i2c_master_byte_transactions_unit #(
   parameter int QueueDepth = i2cm_pkg::QueueDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_dev_byte,
   input  wire logic [7:0]  req_reg_address,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_sda_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_scl_out,
   output logic             rsp_sda_out,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_ack_ok
);

   logic [15:0]                csr_unit_ticks_ff;
   i2cm_pkg::item_type         item;
   i2cm_pkg::queue_status_type q_status;
   logic                       item_pop;

   // Delay unit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_unit_ticks_ff <= i2cm_pkg::UnitTicksReset;
      end else if (csr_wr_en) begin
         csr_unit_ticks_ff <= csr_wr_data;
      end
   end

   i2cm_front #(
      .QueueDepth (QueueDepth)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_dev_byte    (req_dev_byte),
      .req_reg_address (req_reg_address),
      .req_write_data  (req_write_data),
      .req_sda_in      (req_sda_in),
      .item            (item),
      .status          (q_status),
      .item_pop        (item_pop)
   );

   i2cm_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .unit_ticks    (csr_unit_ticks_ff),
      .item          (item),
      .status        (q_status),
      .item_pop      (item_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl_out   (rsp_scl_out),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_read_data (rsp_read_data),
      .rsp_ack_ok    (rsp_ack_ok)
   );

   // The engine only takes a word that the queue holds.
   `I2CM_ASSERT_IMP(a_pop_needs_word, clock, reset, item_pop, q_status.valid)
   // A full queue is never reported empty.
   `I2CM_ASSERT_NEVER(a_full_not_empty, clock, reset, q_status.full && !q_status.valid)
   // The finishing tick already shows the unit idle.
   `I2CM_ASSERT_IMP(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   // With no transaction running both lines are released.
   `I2CM_ASSERT_IMP(a_idle_released, clock, reset, rsp_valid && !rsp_busy_res,
                    rsp_scl_out && rsp_sda_out)

endmodule

`default_nettype wire

/* dv/i2cm_bus_checker.sv */
`timescale 1ns / 1ps
// Checker for the I2C byte transaction unit: watches the req_, rsp_ and csr_ ports,
// predicts the bus levels of every word and compares them with the results.
// Depends on i2cm_pkg for the command codes and the phase types.

module i2cm_bus_checker
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_dev_byte,
   input  logic [7:0]  req_reg_address,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_scl_out,
   input  logic        rsp_sda_out,
   input  logic        rsp_busy_res,
   input  logic        rsp_done_res,
   input  logic [7:0]  rsp_read_data,
   input  logic        rsp_ack_ok,
   output int          error_count,
   output int          checked_words,
   output int          finished_jobs,
   output int          pending_words,
   output logic        engine_busy
);

   // Bus levels and status that one word produces.
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rd;
      logic       ack;
   } bus_levels_type;

   bus_levels_type expected_levels[$];

   // Predicted engine state.
   logic [15:0] unit_ticks;
   logic [5:0]  step_q;
   logic [17:0] ticks_left;
   logic [3:0]  bit_cnt;
   logic [7:0]  shifter;
   logic [7:0]  rx_byte;
   logic [7:0]  job_dev;
   logic [7:0]  job_addr;
   logic [7:0]  job_data;
   logic        ack_all;

   initial begin
      error_count   = 0;
      checked_words = 0;
      finished_jobs = 0;
      pending_words = 0;
      engine_busy   = 1'b0;
   end

   // Line levels, length and end action of each step of the bus program.
   // The byte slots share one six-phase pattern: data low, data high, data low
   // and shift, release, acknowledge clock, hold.
   function automatic phase_type bus_phase(input logic [5:0] s);
      phase_type  p;
      logic [5:0] k;
      logic       in_byte;
      p.scl     = 1'b1;
      p.sda_sel = SdaHi;
      p.units   = 2'd1;
      p.act     = ActNone;
      in_byte = (s >= 6'd4 && s <= 6'd21) || (s >= 6'd28 && s <= 6'd39) ||
                (s >= 6'd48 && s <= 6'd53);
      k = (s >= 6'd48) ? s - 6'd48 : (s >= 6'd28) ? (s - 6'd28) % 6 : (s - 6'd4) % 6;
      if (in_byte) begin
         case (k)
            6'd0: begin
               p.scl     = 1'b0;
               p.sda_sel = SdaBit;
            end
            6'd1: p.sda_sel = SdaBit;
            6'd2: begin
               p.scl     = 1'b0;
               p.sda_sel = SdaBit;
               p.act     = ActTxBit;
            end
            6'd3: p.scl = 1'b0;
            6'd4: begin
               p.units = 2'd3;
               p.act   = ActAck;
            end
            default: begin
               p.scl   = 1'b0;
               p.units = 2'd3;
               if (s == 6'd9 || s == 6'd33)
                  p.act = ActLoadAddr;
               else if (s == 6'd15)
                  p.act = ActLoadData;
               else if (s == 6'd53)
                  p.act = ActRxClr;
            end
         endcase
      end else begin
         case (s)
            6'd1, 6'd25, 6'd45: p.units = 2'd2;
            6'd2, 6'd26, 6'd46: p.sda_sel = SdaLo;
            6'd3, 6'd27, 6'd47: begin
               p.scl     = 1'b0;
               p.sda_sel = SdaLo;
               p.act     = (s == 6'd47) ? ActLoadDevRd : ActLoadDev;
            end
            6'd22, 6'd41, 6'd60: begin
               p.scl     = 1'b0;
               p.sda_sel = SdaLo;
            end
            6'd23, 6'd42, 6'd61: p.sda_sel = SdaLo;
            6'd24, 6'd63: p.act = ActEnd;
            6'd40, 6'd54, 6'd58, 6'd59: p.scl = 1'b0;
            6'd55: begin
               p.units = 2'd2;
               p.act   = ActRxBit;
            end
            6'd56: begin
               p.scl   = 1'b0;
               p.units = 2'd2;
               p.act   = ActRxLoop;
            end
            default: ;
         endcase
      end
      return p;
   endfunction

   // Ticks a step lasts under the current delay unit; a zero unit counts as one.
   function automatic logic [17:0] phase_ticks(input logic [5:0] s);
      logic [17:0] u;
      phase_type   p;
      u = (unit_ticks == 16'd0) ? 18'd1 : {2'b00, unit_ticks};
      p = bus_phase(s);
      return {16'd0, p.units} * u;
   endfunction

   // Advance the engine by one tick and return the levels that tick shows.
   task automatic advance_tick(input logic [1:0] cmd, input logic [7:0] dev,
                               input logic [7:0] addr, input logic [7:0] data,
                               input logic sda_in, output bus_levels_type lv);
      phase_type  ph;
      logic [5:0] nxt;
      lv.scl  = 1'b1;
      lv.sda  = 1'b1;
      lv.done = 1'b0;

      // A command starts a transaction only from the idle step.
      if (step_q == StepIdle && (cmd == CmdWrite || cmd == CmdRead)) begin
         job_dev    = dev;
         job_addr   = addr;
         job_data   = data;
         ack_all    = 1'b1;
         step_q     = (cmd == CmdWrite) ? StepWriteFirst : StepReadFirst;
         ticks_left = phase_ticks(step_q);
      end

      if (step_q != StepIdle) begin
         ph     = bus_phase(step_q);
         lv.scl = ph.scl;
         lv.sda = (ph.sda_sel == SdaBit) ? shifter[7] : (ph.sda_sel == SdaHi);
         if (ticks_left > 18'd1) begin
            ticks_left = ticks_left - 18'd1;
         end else begin
            // Last tick of the step: do its action and move on.
            nxt = step_q + 6'd1;
            case (ph.act)
               ActLoadDev: begin
                  shifter = job_dev;
                  bit_cnt = 4'd0;
               end
               ActLoadAddr: begin
                  shifter = job_addr;
                  bit_cnt = 4'd0;
               end
               ActLoadData: begin
                  shifter = job_data;
                  bit_cnt = 4'd0;
               end
               ActLoadDevRd: begin
                  shifter = job_dev | 8'h01;
                  bit_cnt = 4'd0;
               end
               ActTxBit: begin
                  shifter = {shifter[6:0], 1'b0};
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt < 4'd8)
                     nxt = step_q - 6'd2;
               end
               ActAck: begin
                  if (sda_in)
                     ack_all = 1'b0;
               end
               ActRxClr: begin
                  shifter = 8'h00;
                  bit_cnt = 4'd0;
               end
               ActRxBit: shifter = {shifter[6:0], sda_in};
               ActRxLoop: begin
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt < 4'd8)
                     nxt = step_q - 6'd1;
                  else
                     rx_byte = shifter;
               end
               ActEnd: begin
                  nxt     = StepIdle;
                  lv.done = 1'b1;
                  finished_jobs++;
               end
               default: ;
            endcase
            step_q     = nxt;
            ticks_left = (nxt != StepIdle) ? phase_ticks(nxt) : 18'd0;
         end
      end

      lv.busy = (step_q != StepIdle);
      lv.rd   = rx_byte;
      lv.ack  = ack_all;
   endtask

   task automatic check_field(input string what, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         error_count++;
      end
   endtask

   // Results are compared before new words are predicted, so that a result in the
   // same cycle as a word can never be matched against that word.
   always @(posedge clock) begin : watch
      bus_levels_type want;
      bus_levels_type lv;
      if (reset) begin
         unit_ticks = UnitTicksReset;
         step_q     = StepIdle;
         ticks_left = 18'd0;
         bit_cnt    = 4'd0;
         shifter    = 8'h00;
         rx_byte    = 8'h00;
         job_dev    = 8'h00;
         job_addr   = 8'h00;
         job_data   = 8'h00;
         ack_all    = 1'b1;
         expected_levels.delete();
      end else begin
         if (csr_wr_en)
            unit_ticks = csr_wr_data;

         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: result word with none expected, expected nothing, got %0h",
                        $time, {rsp_scl_out, rsp_sda_out, rsp_busy_res, rsp_done_res,
                                rsp_read_data, rsp_ack_ok});
               error_count++;
            end else begin
               want = expected_levels.pop_front();
               check_field("scl_out", want.scl, rsp_scl_out);
               check_field("sda_out", want.sda, rsp_sda_out);
               check_field("busy_res", want.busy, rsp_busy_res);
               check_field("done_res", want.done, rsp_done_res);
               check_field("read_data", want.rd, rsp_read_data);
               check_field("ack_ok", want.ack, rsp_ack_ok);
               checked_words++;
            end
         end

         if (req_valid && req_ready) begin
            advance_tick(req_command, req_dev_byte, req_reg_address, req_write_data,
                         req_sda_in, lv);
            expected_levels.push_back(lv);
         end
      end
      pending_words <= expected_levels.size();
      engine_busy   <= (step_q != StepIdle);
   end

endmodule

/* dv/tb_i2c_master_byte_transactions_unit.sv */
`timescale 1ns / 1ps
// Testbench top for the I2C byte transaction unit: clock, reset, word stimulus,
// receiver stalls, watchdog and verdict. Depends on i2cm_pkg and i2cm_bus_checker.

module tb_i2c_master_byte_transactions_unit;
   import i2cm_pkg::*;

   // A command code the block treats as a plain tick.
   localparam logic [1:0] CmdUnused = 2'd3;
   localparam int WatchdogLimit = 2000;
   localparam int SqueezeCycles = 80;

   typedef enum {SlaveAcks, SlaveRandom, SlaveSilent} slave_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CmdTick;
   logic [7:0]  req_dev_byte = 8'h00;
   logic [7:0]  req_reg_address = 8'h00;
   logic [7:0]  req_write_data = 8'h00;
   logic        req_sda_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_scl_out;
   logic        rsp_sda_out;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_data;
   logic        rsp_ack_ok;

   int          error_count;
   int          checked_words;
   int          finished_jobs;
   int          pending_words;
   logic        engine_busy;

   int             words_sent = 0;
   int             burst_left = 1;
   int             quiet_cycles = 0;
   bit             squeeze_req = 1'b0;
   bit             squeeze_done = 1'b0;
   slave_kind_type slave_kind = SlaveRandom;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   i2c_master_byte_transactions_unit dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_dev_byte    (req_dev_byte),
      .req_reg_address (req_reg_address),
      .req_write_data  (req_write_data),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl_out     (rsp_scl_out),
      .rsp_sda_out     (rsp_sda_out),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_read_data   (rsp_read_data),
      .rsp_ack_ok      (rsp_ack_ok)
   );

   i2cm_bus_checker bus_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_dev_byte    (req_dev_byte),
      .req_reg_address (req_reg_address),
      .req_write_data  (req_write_data),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl_out     (rsp_scl_out),
      .rsp_sda_out     (rsp_sda_out),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_read_data   (rsp_read_data),
      .rsp_ack_ok      (rsp_ack_ok),
      .error_count     (error_count),
      .checked_words   (checked_words),
      .finished_jobs   (finished_jobs),
      .pending_words   (pending_words),
      .engine_busy     (engine_busy)
   );

   // SDA level a slave of the given kind returns; acks are low levels.
   function automatic logic slave_sda(input slave_kind_type k);
      case (k)
         SlaveAcks:   return ($urandom_range(0, 7) == 0);
         SlaveSilent: return ($urandom_range(0, 7) != 0);
         default:     return $urandom_range(0, 1);
      endcase
   endfunction

   // Offer one word and hold it until accepted; bursts end in a random gap.
   task automatic push_word(input logic [1:0] cmd, input logic [7:0] dev,
                            input logic [7:0] addr, input logic [7:0] data,
                            input logic sda);
      int gap;
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_dev_byte    <= dev;
      req_reg_address <= addr;
      req_write_data  <= data;
      req_sda_in      <= sda;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 16);
      end
   endtask

   // Stop sending and wait until every expected result word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic set_unit_ticks(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One complete transaction: the command, two commands that must be ignored
   // while busy, then ticks with a fixed SDA level until the engine is idle.
   task automatic run_job(input logic [1:0] cmd, input logic [7:0] dev,
                          input logic [7:0] addr, input logic [7:0] data,
                          input logic sda);
      push_word(cmd, dev, addr, data, sda);
      push_word((cmd == CmdWrite) ? CmdRead : CmdWrite, ~dev, ~addr, ~data, sda);
      push_word(CmdUnused, dev, addr, data, sda);
      while (engine_busy)
         push_word(CmdTick, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), sda);
   endtask

   // Mostly well-formed traffic: a new command soon after each transaction ends,
   // with stray commands and random fields while busy.
   task automatic run_random(input int count);
      logic [1:0] cmd;
      for (int i = 0; i < count; i++) begin
         if (!engine_busy && $urandom_range(0, 3) != 0) begin
            cmd        = $urandom_range(0, 1) ? CmdWrite : CmdRead;
            slave_kind = slave_kind_type'($urandom_range(0, 2));
         end else if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
               0:       cmd = CmdTick;
               1:       cmd = CmdWrite;
               2:       cmd = CmdRead;
               default: cmd = CmdUnused;
            endcase
         end else begin
            cmd = CmdTick;
         end
         push_word(cmd, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), slave_sda(slave_kind));
      end
   endtask

   // Receiver: stretches of always ready, mostly ready and mostly stalled, plus
   // one long hold-off while the sender keeps going.
   initial begin : rsp_side
      int mode;
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (squeeze_req && !squeeze_done) begin
            rsp_ready <= 1'b0;
            repeat (SqueezeCycles) @(posedge clock);
            squeeze_done = 1'b1;
         end
         mode = $urandom_range(0, 2);
         span = $urandom_range(8, 64);
         repeat (span) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Watchdog: the run is stuck if no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Write at the reset delay unit, with the unit changed to zero mid-transaction.
      push_word(CmdWrite, 8'hFF, 8'h00, 8'hA5, 1'b0);
      repeat (20) push_word(CmdTick, 8'h00, 8'h00, 8'h00, 1'b0);
      drain_results();
      set_unit_ticks(16'd0);
      while (engine_busy) push_word(CmdTick, 8'hFF, 8'hFF, 8'hFF, 1'b0);

      // Read from an odd device with every ack missing, then idle words of both
      // tick codes, then a fully acknowledged read.
      run_job(CmdRead, 8'hFF, 8'hFF, 8'h00, 1'b1);
      push_word(CmdUnused, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_word(CmdTick, 8'h00, 8'h00, 8'h00, 1'b0);
      run_job(CmdRead, 8'h00, 8'h00, 8'hFF, 1'b0);

      // Random traffic under several delay units.
      drain_results();
      set_unit_ticks(16'd1);
      run_random(40);
      drain_results();
      set_unit_ticks(16'd2);
      squeeze_req = 1'b1;
      run_random(100);
      drain_results();
      set_unit_ticks(16'd3);
      run_random(30);
      drain_results();
      set_unit_ticks(16'd1);
      run_random(30);

      // Largest delay unit: a read that only gets into its first phase.
      drain_results();
      set_unit_ticks(16'hFFFF);
      push_word(CmdRead, 8'h5A, 8'hC3, 8'h3C, 1'b1);
      run_random(10);

      drain_results();
      repeat (4) @(posedge clock);

      $display("Run covered %0d words sent and %0d results checked, with %0d transactions",
               words_sent, checked_words, finished_jobs);
      $display("finished over delay units of 100, 0, 1, 2, 3 and 65535 ticks.");
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
